// ===== sv/smau_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the small matrix arithmetic unit.
// No dependencies; used by the top level small_matrix_arithmetic_unit.
package smau_pkg;

  // Store geometry and number format.
  localparam int MAX_DIM   = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ELEM_N    = MAX_DIM * MAX_DIM;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = $clog2(ELEM_N);

  // Fixed field widths of the streaming words.
  localparam int CMD_W   = 3;
  localparam int ROW_W   = 2;
  localparam int TDATA_W = ((2 * ROW_W + DATA_W + 7) / 8) * 8;
  localparam int TPAD_W  = TDATA_W - 2 * ROW_W - DATA_W;

  // Full product and accumulator widths: shifted products summed over one row.
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W - FRAC_BITS + $clog2(MAX_DIM) + 1;

  // Configuration register file.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int SIZE_W = 3;
  localparam logic [SIZE_W-1:0]   SIZE_RESET = SIZE_W'(4);
  localparam logic [CFG_AW-3:0]   REG_SIZE   = '0;

  // Fixed-point 1.0, the diagonal value of a store after reset.
  localparam logic signed [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRAC_BITS;

  // Commands carried in the input word's tuser field.
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A  = 3'd0,
    CMD_WR_B  = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_ADD   = 3'd3,
    CMD_SUB   = 3'd4,
    CMD_SCALE = 3'd5,
    CMD_TRANS = 3'd6,
    CMD_NOP   = 3'd7
  } cmd_t;

  // Row-major element address inside a store.
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

endpackage

// ===== sv/smau_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instantiated by the matrix unit for its element stores.
module smau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/small_matrix_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Top level of the small matrix arithmetic unit: sequencer, datapath, config port.
// Depends on smau_pkg and on smau_ram for the A, B and transpose scratch stores.
//
// Usage:
//   Input words (in_*) carry a command in in_tuser and the row, column and
//   operand in in_tdata. Element writes to A or B give no result. A run
//   command (multiply, add, subtract, scale, transpose) works on the active
//   size-by-size corner and streams one result word per element on out_* in
//   row-major order, with out_tlast on the final element and out_tuser set
//   when the element was clipped to the 32-bit range. Elements are worked one
//   at a time: the one shared multiplier and the single read port of each
//   store take each element's terms in turn, and the element drains before
//   the next one starts. A transpose then copies its result back into A. A new
//   command is taken once the previous run has captured its last element and,
//   for a transpose, finished the copy-back, while its last result may still
//   wait at the output. Reset returns both stores to identity (per-entry
//   valid flags, no clearing pass) and the size register to 4. A stalled
//   receiver holds out_* steady and stalls the element sequencer after one
//   more element is buffered.
//   matrix_size is written over the APB-style cfg_* port at byte address 0.
module small_matrix_arithmetic_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata fields from bit 0: row_index[2], col_index[2], operand_value[32], pad
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [smau_pkg::TDATA_W-1:0] in_tdata,
  // in_tuser fields from bit 0: command[3]
  input  logic [smau_pkg::CMD_W-1:0]   in_tuser,
  // out_tdata fields from bit 0: out_row[2], out_col[2], out_value[32], pad
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [smau_pkg::TDATA_W-1:0] out_tdata,
  // out_tuser fields from bit 0: saturated[1]
  output logic                         out_tuser,
  output logic                         out_tlast,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [smau_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [smau_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [smau_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  import smau_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WB,
    ST_WB_DRAIN
  } state_t;

  // Control state.
  state_t              state_r;
  logic [SIZE_W-1:0]   size_r;
  logic [ELEM_N-1:0]   va_r;
  logic [ELEM_N-1:0]   vb_r;
  logic                issue_v_r;
  logic                rd_v_r;
  logic                p_v_r;
  logic                acc_v_r;
  logic                res_valid_r;
  logic                out_valid_r;
  logic                wb_v_r;

  // Run context and counters.
  cmd_t                cmd_r;
  logic signed [DATA_W-1:0] scalar_r;
  logic [IDX_W-1:0]    n_last_r;
  logic [IDX_W-1:0]    r_r;
  logic [IDX_W-1:0]    c_r;
  logic [IDX_W-1:0]    i_r;
  logic [IDX_W-1:0]    wb_r;
  logic [IDX_W-1:0]    wb_c_r;
  logic [ADDR_W-1:0]   wb_addr_r;

  // Pipeline tags and data.
  logic                rd_first_r;
  logic                rd_last_r;
  logic                p_first_r;
  logic                p_last_r;
  logic                acc_last_r;
  logic                rd_va_r;
  logic                rd_vb_r;
  logic                rd_adiag_r;
  logic                rd_bdiag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ROW_W-1:0]    res_row_r;
  logic [ROW_W-1:0]    res_col_r;
  logic [DATA_W-1:0]   res_value_r;
  logic                res_sat_r;
  logic                res_last_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [ROW_W-1:0]    out_col_r;
  logic [DATA_W-1:0]   out_value_r;
  logic                out_sat_r;
  logic                out_last_r;

  // Combinational signals.
  logic                in_acc;
  cmd_t                in_cmd;
  logic [ROW_W-1:0]    in_row;
  logic [ROW_W-1:0]    in_col;
  logic [DATA_W-1:0]   in_value;
  logic                in_in_range;
  logic [ADDR_W-1:0]   in_addr;
  logic                run_cmd_acc;
  logic [IDX_W-1:0]    n_last;
  logic                cfg_wr;
  logic [CFG_AW-3:0]   cfg_idx;
  logic                elem_start;
  logic                term_last;
  logic                run_last;
  logic                cap;
  logic                out_load;
  logic                wb_last;
  logic [ADDR_W-1:0]   a_raddr;
  logic [ADDR_W-1:0]   b_raddr;
  logic                a_diag;
  logic                b_diag;
  logic                a_we;
  logic [ADDR_W-1:0]   a_waddr;
  logic [DATA_W-1:0]   a_wdata;
  logic                b_we;
  logic [ADDR_W-1:0]   b_waddr;
  logic                t_we;
  logic [ADDR_W-1:0]   t_waddr;
  logic [ADDR_W-1:0]   t_raddr;
  logic [DATA_W-1:0]   a_q;
  logic [DATA_W-1:0]   b_q;
  logic [DATA_W-1:0]   t_q;
  logic signed [DATA_W-1:0] a_val;
  logic signed [DATA_W-1:0] b_val;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                sat_pos;
  logic                sat_neg;
  logic [DATA_W-1:0]   sat_value;

  // Configuration port: one register, always ready.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & (cfg_idx == REG_SIZE);
  assign cfg_prdata = (cfg_idx == REG_SIZE) ? CFG_DW'(size_r) : '0;

  // Input word unpacking.
  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid & in_tready;
  assign in_cmd      = cmd_t'(in_tuser);
  assign in_row      = in_tdata[ROW_W-1:0];
  assign in_col      = in_tdata[2*ROW_W-1:ROW_W];
  assign in_value    = in_tdata[2*ROW_W +: DATA_W];
  assign in_in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign in_addr     = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
  assign run_cmd_acc = in_acc && (in_cmd inside {CMD_MUL, CMD_ADD, CMD_SUB, CMD_SCALE,
                                                 CMD_TRANS});

  // Effective dimension minus one, with the size clamped to 2..MAX_DIM.
  always_comb begin
    if (int'(size_r) < 2) begin
      n_last = IDX_W'(1);
    end else if (int'(size_r) > MAX_DIM) begin
      n_last = IDX_W'(MAX_DIM - 1);
    end else begin
      n_last = IDX_W'(int'(size_r) - 1);
    end
  end

  // Sequencer conditions. One element is in flight at a time.
  assign elem_start = (state_r == ST_RUN) && !issue_v_r && !rd_v_r && !p_v_r && !acc_v_r &&
                      !res_valid_r;
  assign term_last  = (cmd_r != CMD_MUL) || (i_r == n_last_r);
  assign run_last   = (r_r == n_last_r) && (c_r == n_last_r);
  assign cap        = acc_v_r && acc_last_r;
  assign out_load   = res_valid_r && (!out_valid_r || out_tready);
  assign wb_last    = (wb_r == n_last_r) && (wb_c_r == n_last_r);

  // Store read addresses for the term being issued.
  always_comb begin
    case (cmd_r)
      CMD_MUL: begin
        a_raddr = elem_addr(r_r, i_r);
        b_raddr = elem_addr(i_r, c_r);
        a_diag  = (r_r == i_r);
        b_diag  = (i_r == c_r);
      end
      CMD_TRANS: begin
        a_raddr = elem_addr(c_r, r_r);
        b_raddr = elem_addr(r_r, c_r);
        a_diag  = (r_r == c_r);
        b_diag  = (r_r == c_r);
      end
      default: begin
        a_raddr = elem_addr(r_r, c_r);
        b_raddr = elem_addr(r_r, c_r);
        a_diag  = (r_r == c_r);
        b_diag  = (r_r == c_r);
      end
    endcase
  end

  // Store write ports: element writes, transpose scratch writes, and the transpose copy back into A.
  assign a_we    = (in_acc && (in_cmd == CMD_WR_A) && in_in_range) || wb_v_r;
  assign a_waddr = wb_v_r ? wb_addr_r : in_addr;
  assign a_wdata = wb_v_r ? t_q : in_value;
  assign b_we    = in_acc && (in_cmd == CMD_WR_B) && in_in_range;
  assign b_waddr = in_addr;
  assign t_we    = cap && (cmd_r == CMD_TRANS);
  assign t_waddr = elem_addr(r_r, c_r);
  assign t_raddr = elem_addr(wb_r, wb_c_r);

  smau_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_N)) u_store_a (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (a_waddr),
    .wr_data (a_wdata),
    .rd_addr (a_raddr),
    .rd_data (a_q)
  );

  smau_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_N)) u_store_b (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (in_value),
    .rd_addr (b_raddr),
    .rd_data (b_q)
  );

  smau_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_N)) u_store_t (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (sat_value),
    .rd_addr (t_raddr),
    .rd_data (t_q)
  );

  // Operands: an entry never written reads as the identity value.
  assign a_val = rd_va_r ? $signed(a_q) : (rd_adiag_r ? ONE_VAL : '0);
  assign b_val = rd_vb_r ? $signed(b_q) : (rd_bdiag_r ? ONE_VAL : '0);
  assign mul_b = (cmd_r == CMD_SCALE) ? scalar_r : b_val;
  assign mul_p = a_val * mul_b;

  // Term computation per command.
  always_comb begin
    case (cmd_r)
      CMD_MUL, CMD_SCALE: prod_nxt = mul_p;
      CMD_ADD:            prod_nxt = PROD_W'(a_val) + PROD_W'(b_val);
      CMD_SUB:            prod_nxt = PROD_W'(a_val) - PROD_W'(b_val);
      CMD_TRANS:          prod_nxt = PROD_W'(a_val);
      default:            prod_nxt = '0;
    endcase
  end

  // Products are truncated toward minus infinity, then accumulated.
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign term    = ((cmd_r == CMD_MUL) || (cmd_r == CMD_SCALE)) ? ACC_W'(prod_sh)
                                                                : ACC_W'(prod_r);
  assign acc_nxt = (p_first_r ? '0 : acc_r) + term;

  // Saturation to the signed 32-bit range.
  assign sat_pos   = !acc_r[ACC_W-1] && (|acc_r[ACC_W-2:DATA_W-1]);
  assign sat_neg   = acc_r[ACC_W-1] && !(&acc_r[ACC_W-2:DATA_W-1]);
  assign sat_value = sat_pos ? {1'b0, {(DATA_W-1){1'b1}}} :
                     sat_neg ? {1'b1, {(DATA_W-1){1'b0}}} : acc_r[DATA_W-1:0];

  // State machine, valid flags and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_RESET;
      va_r        <= '0;
      vb_r        <= '0;
      issue_v_r   <= 1'b0;
      rd_v_r      <= 1'b0;
      p_v_r       <= 1'b0;
      acc_v_r     <= 1'b0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      wb_v_r      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        size_r <= cfg_pwdata[SIZE_W-1:0];
      end
      if (a_we) begin
        va_r[a_waddr] <= 1'b1;
      end
      if (b_we) begin
        vb_r[b_waddr] <= 1'b1;
      end
      rd_v_r      <= issue_v_r;
      p_v_r       <= rd_v_r;
      acc_v_r     <= p_v_r;
      wb_v_r      <= (state_r == ST_WB);
      res_valid_r <= cap | (res_valid_r & ~out_load);
      out_valid_r <= out_load | (out_valid_r & ~out_tready);
      if (elem_start) begin
        issue_v_r <= 1'b1;
      end else if (issue_v_r && term_last) begin
        issue_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (run_cmd_acc) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cap && run_last) begin
            state_r <= (cmd_r == CMD_TRANS) ? ST_WB : ST_IDLE;
          end
        end
        ST_WB: begin
          if (wb_last) begin
            state_r <= ST_WB_DRAIN;
          end
        end
        ST_WB_DRAIN: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Run context, counters and datapath registers.
  always_ff @(posedge clk) begin
    if (run_cmd_acc) begin
      cmd_r    <= in_cmd;
      scalar_r <= $signed(in_value);
      n_last_r <= n_last;
      r_r      <= '0;
      c_r      <= '0;
    end else if (cap) begin
      if (c_r == n_last_r) begin
        c_r <= '0;
        r_r <= r_r + IDX_W'(1);
      end else begin
        c_r <= c_r + IDX_W'(1);
      end
    end
    if (elem_start) begin
      i_r <= '0;
    end else if (issue_v_r && !term_last) begin
      i_r <= i_r + IDX_W'(1);
    end

    // Term tags travel with the pipeline.
    rd_first_r <= (i_r == '0);
    rd_last_r  <= term_last;
    p_first_r  <= rd_first_r;
    p_last_r   <= rd_last_r;
    acc_last_r <= p_last_r;
    rd_va_r    <= va_r[a_raddr];
    rd_vb_r    <= vb_r[b_raddr];
    rd_adiag_r <= a_diag;
    rd_bdiag_r <= b_diag;
    if (rd_v_r) begin
      prod_r <= prod_nxt;
    end
    if (p_v_r) begin
      acc_r <= acc_nxt;
    end

    // Finished element into the holding register, then to the output.
    if (cap) begin
      res_row_r   <= ROW_W'(r_r);
      res_col_r   <= ROW_W'(c_r);
      res_value_r <= sat_value;
      res_sat_r   <= sat_pos | sat_neg;
      res_last_r  <= run_last;
    end
    if (out_load) begin
      out_row_r   <= res_row_r;
      out_col_r   <= res_col_r;
      out_value_r <= res_value_r;
      out_sat_r   <= res_sat_r;
      out_last_r  <= res_last_r;
    end

    // Transpose copy-back sweep over the active corner.
    if (cap && run_last) begin
      wb_r   <= '0;
      wb_c_r <= '0;
    end else if (state_r == ST_WB) begin
      if (wb_c_r == n_last_r) begin
        wb_c_r <= '0;
        wb_r   <= wb_r + IDX_W'(1);
      end else begin
        wb_c_r <= wb_c_r + IDX_W'(1);
      end
    end
    wb_addr_r <= t_raddr;
  end

  // Output word.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{TPAD_W{1'b0}}, out_value_r, out_col_r, out_row_r};
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

  // No command is taken while an element or the copy-back is still in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !issue_v_r && !rd_v_r && !p_v_r && !acc_v_r && !wb_v_r)
    else $error("input word taken while the datapath is busy");

  // A finished element never overwrites one still waiting for the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    cap |-> !res_valid_r)
    else $error("holding register overwritten");

  // A transposed element is a plain copy and cannot clip.
  assert property (@(posedge clk) disable iff (!rst_n)
    cap && (cmd_r == CMD_TRANS) |-> !sat_pos && !sat_neg)
    else $error("transpose result flagged as saturated");

  // The copy-back into A never overlaps a pending read of the stores.
  assert property (@(posedge clk) disable iff (!rst_n)
    wb_v_r |-> !issue_v_r && !rd_v_r && (cmd_r == CMD_TRANS))
    else $error("copy-back overlaps a run");

endmodule
